// File: rtl/core/esrb_pkg.sv
package esrb_pkg;

   // Fixed limits
   localparam int SPEED_W   = 7;
   localparam int COUNT_W   = 32;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int STEP_W    = 4;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd126;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] REG_COUNTS_PER_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_DIRECTION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_PER_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_HYSTERESIS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BRAKE_TICK_MS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DECEL_PER_TICK    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_PER_TICK    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TOUCH_DEBOUNCE_MS = 3'd7;

   // Register reset values
   localparam logic [7:0]  RST_COUNTS_PER_STEP   = 8'd4;
   localparam logic        RST_INVERT_DIRECTION  = 1'b0;
   localparam logic [6:0]  RST_SPEED_PER_STEP    = 7'd1;
   localparam logic [7:0]  RST_STEP_HYSTERESIS   = 8'd1;
   localparam logic [15:0] RST_BRAKE_TICK_MS     = 16'd50;
   localparam logic [6:0]  RST_DECEL_PER_TICK    = 7'd2;
   localparam logic [6:0]  RST_ACCEL_PER_TICK    = 7'd1;
   localparam logic [15:0] RST_TOUCH_DEBOUNCE_MS = 16'd200;

   typedef logic [STEP_W-1:0] step_type;

   // Program addresses
   localparam step_type STEP_WAIT   = 4'd0;
   localparam step_type STEP_ENC    = 4'd1;
   localparam step_type STEP_DIV    = 4'd2;
   localparam step_type STEP_POST   = 4'd3;
   localparam step_type STEP_MUL    = 4'd4;
   localparam step_type STEP_DEMAND = 4'd5;
   localparam step_type STEP_HOLD   = 4'd6;
   localparam step_type STEP_BRAKE  = 4'd7;
   localparam step_type STEP_EMIT   = 4'd8;

   // Datapath operation selected by a control word
   typedef enum logic [3:0] {
      OP_WAIT,
      OP_ENC,
      OP_DIV,
      OP_POST,
      OP_MUL,
      OP_DEMAND,
      OP_HOLD,
      OP_BRAKE,
      OP_EMIT
   } op_type;

   // Sequencing: advance, jump on flag, or stay while flag
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_BRANCH,
      JMP_WAIT
   } jmp_type;

   typedef struct packed {
      op_type   op;
      jmp_type  jmp;
      step_type target;
   } ctrl_type;

endpackage

// File: rtl/core/esrb_req_if.sv
interface esrb_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [esrb_pkg::COUNT_W-1:0] encoder_count;
   logic                                touching;
   logic        [esrb_pkg::TIME_W-1:0]  now_ms;

   modport source (output valid, output encoder_count, output touching, output now_ms,
                   input ready);
   modport sink   (input valid, input encoder_count, input touching, input now_ms,
                   output ready);
endinterface

// File: rtl/core/esrb_rsp_if.sv
interface esrb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [esrb_pkg::SPEED_W-1:0]  speed;
   logic                          speed_changed;
   logic [esrb_pkg::SPEED_W-1:0]  demand;
   logic                          brake_holding;
   logic                          brake_recovering;

   modport source (output valid, output speed, output speed_changed, output demand,
                   output brake_holding, output brake_recovering, input ready);
   modport sink   (input valid, input speed, input speed_changed, input demand,
                   input brake_holding, input brake_recovering, output ready);
endinterface

// File: rtl/core/esrb_seq.sv
module esrb_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                flag,
   output esrb_pkg::ctrl_type  ctrl
);

   esrb_pkg::step_type step_ff;
   esrb_pkg::step_type step_in;

   // Control store: one word per program step
   function automatic esrb_pkg::ctrl_type rom_word(input esrb_pkg::step_type s);
      esrb_pkg::ctrl_type w;
      w = '{op: esrb_pkg::OP_WAIT, jmp: esrb_pkg::JMP_WAIT, target: esrb_pkg::STEP_ENC};
      unique case (s)
         esrb_pkg::STEP_WAIT:
            w = '{op: esrb_pkg::OP_WAIT, jmp: esrb_pkg::JMP_WAIT,
                  target: esrb_pkg::STEP_ENC};
         esrb_pkg::STEP_ENC:
            w = '{op: esrb_pkg::OP_ENC, jmp: esrb_pkg::JMP_BRANCH,
                  target: esrb_pkg::STEP_HOLD};
         esrb_pkg::STEP_DIV:
            w = '{op: esrb_pkg::OP_DIV, jmp: esrb_pkg::JMP_WAIT,
                  target: esrb_pkg::STEP_POST};
         esrb_pkg::STEP_POST:
            w = '{op: esrb_pkg::OP_POST, jmp: esrb_pkg::JMP_BRANCH,
                  target: esrb_pkg::STEP_HOLD};
         esrb_pkg::STEP_MUL:
            w = '{op: esrb_pkg::OP_MUL, jmp: esrb_pkg::JMP_NEXT,
                  target: esrb_pkg::STEP_WAIT};
         esrb_pkg::STEP_DEMAND:
            w = '{op: esrb_pkg::OP_DEMAND, jmp: esrb_pkg::JMP_NEXT,
                  target: esrb_pkg::STEP_WAIT};
         esrb_pkg::STEP_HOLD:
            w = '{op: esrb_pkg::OP_HOLD, jmp: esrb_pkg::JMP_NEXT,
                  target: esrb_pkg::STEP_WAIT};
         esrb_pkg::STEP_BRAKE:
            w = '{op: esrb_pkg::OP_BRAKE, jmp: esrb_pkg::JMP_NEXT,
                  target: esrb_pkg::STEP_WAIT};
         esrb_pkg::STEP_EMIT:
            w = '{op: esrb_pkg::OP_EMIT, jmp: esrb_pkg::JMP_WAIT,
                  target: esrb_pkg::STEP_WAIT};
         default:
            w = '{op: esrb_pkg::OP_WAIT, jmp: esrb_pkg::JMP_WAIT,
                  target: esrb_pkg::STEP_ENC};
      endcase
      return w;
   endfunction

   assign ctrl = rom_word(step_ff);

   // Pick the next step from the jump kind and the datapath flag
   always_comb begin
      step_in = step_ff + 1'b1;
      unique case (ctrl.jmp)
         esrb_pkg::JMP_NEXT:   step_in = step_ff + 1'b1;
         esrb_pkg::JMP_BRANCH: step_in = flag ? ctrl.target : step_ff + 1'b1;
         esrb_pkg::JMP_WAIT:   step_in = flag ? step_ff : ctrl.target;
         default:              step_in = esrb_pkg::STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= esrb_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/core/encoder_speed_ramp_with_brake.sv
// An accepted sample runs encode, a serial divide of the accumulator magnitude by
//   counts_per_step, post, multiply, demand, hold, brake and emit; the first sample
//   or a zero delta skips from encode to hold, as a step count under the hysteresis
//   does from post. One sample at a time; the next is taken only after emit.
//   A waiting result stalls the next sample only in its emit step.
// Reset: synchronous, active high; registers return to defaults, tracking state clears.
module encoder_speed_ramp_with_brake (
   input  logic                                  clock,
   input  logic                                  reset,
   esrb_req_if.sink                              req_chan,
   esrb_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [esrb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [esrb_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   esrb_pkg::ctrl_type ctrl;
   logic               flag;

   // Configuration registers
   logic [7:0]  cps_ff,   cps_in;
   logic        inv_ff,   inv_in;
   logic [6:0]  sps_ff,   sps_in;
   logic [7:0]  hyst_ff,  hyst_in;
   logic [15:0] tick_ff,  tick_in;
   logic [6:0]  decel_ff, decel_in;
   logic [6:0]  accel_ff, accel_in;
   logic [15:0] deb_ff,   deb_in;

   // Latched sample
   logic [31:0] cnt_ff,   cnt_in;
   logic        touch_ff, touch_in;
   logic [31:0] now_ff,   now_in;

   // Tracking state
   logic              seen_ff,   seen_in;
   logic [31:0]       last_ff,   last_in;
   logic signed [8:0] rem_ff,    rem_in;
   logic [6:0]        cur_ff,    cur_in;
   logic [6:0]        dem_ff,    dem_in;
   logic              hold_ff,   hold_in;
   logic              rec_ff,    rec_in;
   logic [31:0]       lst_ff,    lst_in;
   logic [31:0]       lht_ff,    lht_in;

   // Divider and scratch
   logic [31:0] divq_ff,  divq_in;
   logic [7:0]  divr_ff,  divr_in;
   logic [4:0]  divc_ff,  divc_in;
   logic        neg_ff,   neg_in;
   logic [13:0] prod_ff,  prod_in;
   logic        chg_ff,   chg_in;

   // Output register
   logic        ovalid_ff, ovalid_in;
   logic [6:0]  ospeed_ff, ospeed_in;
   logic        ochg_ff,   ochg_in;
   logic [6:0]  odem_ff,   odem_in;
   logic        ohold_ff,  ohold_in;
   logic        orec_ff,   orec_in;

   esrb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flag  (flag),
      .ctrl  (ctrl)
   );

   function automatic logic [6:0] clamp_speed(input logic signed [15:0] v);
      logic [6:0] r;
      if (v < 16'sd0) begin
         r = 7'd0;
      end else if (v > $signed({9'd0, esrb_pkg::SPEED_MAX})) begin
         r = esrb_pkg::SPEED_MAX;
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

   assign req_chan.ready = (ctrl.op == esrb_pkg::OP_WAIT);

   assign rsp_chan.valid            = ovalid_ff;
   assign rsp_chan.speed            = ospeed_ff;
   assign rsp_chan.speed_changed    = ochg_ff;
   assign rsp_chan.demand           = odem_ff;
   assign rsp_chan.brake_holding    = ohold_ff;
   assign rsp_chan.brake_recovering = orec_ff;

   // Configuration writes
   always_comb begin
      cps_in   = cps_ff;
      inv_in   = inv_ff;
      sps_in   = sps_ff;
      hyst_in  = hyst_ff;
      tick_in  = tick_ff;
      decel_in = decel_ff;
      accel_in = accel_ff;
      deb_in   = deb_ff;
      if (csr_we) begin
         unique case (csr_index)
            esrb_pkg::REG_COUNTS_PER_STEP:   cps_in   = csr_wdata[7:0];
            esrb_pkg::REG_INVERT_DIRECTION:  inv_in   = csr_wdata[0];
            esrb_pkg::REG_SPEED_PER_STEP:    sps_in   = csr_wdata[6:0];
            esrb_pkg::REG_STEP_HYSTERESIS:   hyst_in  = csr_wdata[7:0];
            esrb_pkg::REG_BRAKE_TICK_MS:     tick_in  = csr_wdata;
            esrb_pkg::REG_DECEL_PER_TICK:    decel_in = csr_wdata[6:0];
            esrb_pkg::REG_ACCEL_PER_TICK:    accel_in = csr_wdata[6:0];
            esrb_pkg::REG_TOUCH_DEBOUNCE_MS: deb_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Datapath: one operation per control word
   always_comb begin
      logic [31:0]       pos;
      logic [31:0]       delta;
      logic [33:0]       acc;
      logic [33:0]       acc_mag;
      logic [7:0]        cps_eff;
      logic [8:0]        part;
      logic [8:0]        diff;
      logic              ge;
      logic [8:0]        rmag;
      logic [6:0]        mag7;
      logic signed [15:0] sum;
      logic [6:0]        nd;
      logic [6:0]        nv;
      logic              release_hold;
      logic [31:0]       lst_eff;
      logic              busy;

      cnt_in   = cnt_ff;
      touch_in = touch_ff;
      now_in   = now_ff;
      seen_in  = seen_ff;
      last_in  = last_ff;
      rem_in   = rem_ff;
      cur_in   = cur_ff;
      dem_in   = dem_ff;
      hold_in  = hold_ff;
      rec_in   = rec_ff;
      lst_in   = lst_ff;
      lht_in   = lht_ff;
      divq_in  = divq_ff;
      divr_in  = divr_ff;
      divc_in  = divc_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      chg_in   = chg_ff;
      ospeed_in = ospeed_ff;
      ochg_in   = ochg_ff;
      odem_in   = odem_ff;
      ohold_in  = ohold_ff;
      orec_in   = orec_ff;
      ovalid_in = ovalid_ff & ~rsp_chan.ready;
      flag      = 1'b0;

      pos     = inv_ff ? (32'd0 - cnt_ff) : cnt_ff;
      delta   = pos - last_ff;
      acc     = {{25{rem_ff[8]}}, rem_ff} + {{2{delta[31]}}, delta};
      acc_mag = acc[33] ? (34'd0 - acc) : acc;
      cps_eff = (cps_ff == 8'd0) ? 8'd1 : cps_ff;
      part    = {divr_ff, divq_ff[31]};
      diff    = part - {1'b0, cps_eff};
      ge      = (part >= {1'b0, cps_eff});
      rmag    = {1'b0, divr_ff};
      mag7    = (|divq_ff[31:7]) ? 7'd127 : divq_ff[6:0];
      sum     = neg_ff ? ($signed({9'd0, dem_ff}) - $signed({2'd0, prod_ff}))
                       : ($signed({9'd0, dem_ff}) + $signed({2'd0, prod_ff}));
      nd      = clamp_speed(sum);
      nv      = cur_ff;
      release_hold = 1'b0;
      lst_eff = lst_ff;
      busy    = ovalid_ff & ~rsp_chan.ready;

      unique case (ctrl.op)
         // Take the next transaction
         esrb_pkg::OP_WAIT: begin
            flag = ~req_chan.valid;
            if (req_chan.valid) begin
               cnt_in   = req_chan.encoder_count;
               touch_in = req_chan.touching;
               now_in   = req_chan.now_ms;
               chg_in   = 1'b0;
            end
         end
         // Latch position, form the accumulator and load the divider
         esrb_pkg::OP_ENC: begin
            seen_in = 1'b1;
            last_in = pos;
            flag    = ~seen_ff | (delta == 32'd0);
            divq_in = acc_mag[31:0];
            divr_in = 8'd0;
            divc_in = 5'd31;
            neg_in  = acc[33];
         end
         // One quotient bit per cycle
         esrb_pkg::OP_DIV: begin
            flag    = (divc_ff != 5'd0);
            divc_in = divc_ff - 5'd1;
            divq_in = {divq_ff[30:0], ge};
            divr_in = ge ? diff[7:0] : part[7:0];
         end
         // Signed remainder, drop small step counts
         esrb_pkg::OP_POST: begin
            rem_in = neg_ff ? (9'd0 - rmag) : rmag;
            flag   = (divq_ff == 32'd0) || (divq_ff < {24'd0, hyst_ff});
         end
         // Saturated step count times speed per step
         esrb_pkg::OP_MUL: begin
            prod_in = {7'd0, mag7} * {7'd0, sps_ff};
         end
         // Move the demand; follow it when no brake activity
         esrb_pkg::OP_DEMAND: begin
            if (nd != dem_ff) begin
               dem_in = nd;
               if (!hold_ff && !rec_ff && nd != cur_ff) begin
                  cur_in = nd;
                  chg_in = 1'b1;
               end
            end
         end
         // Start a hold once the debounce time has passed
         esrb_pkg::OP_HOLD: begin
            if (touch_ff && !hold_ff && ((now_ff - lht_ff) > {16'd0, deb_ff})) begin
               hold_in = 1'b1;
               rec_in  = 1'b0;
               lst_in  = now_ff;
               lht_in  = now_ff;
            end
         end
         // Brake ticks while holding, recovery ticks after release
         esrb_pkg::OP_BRAKE: begin
            if (hold_ff && touch_ff) begin
               if ((now_ff - lst_ff) >= {16'd0, tick_ff}) begin
                  lst_in = now_ff;
                  nv = clamp_speed($signed({9'd0, cur_ff}) - $signed({9'd0, decel_ff}));
               end
            end else begin
               release_hold = hold_ff;
               if (release_hold) begin
                  hold_in = 1'b0;
                  rec_in  = 1'b1;
                  lst_in  = now_ff;
                  lst_eff = now_ff;
               end
               if (rec_ff || release_hold) begin
                  if (cur_ff == dem_ff) begin
                     rec_in = 1'b0;
                  end else if ((now_ff - lst_eff) >= {16'd0, tick_ff}) begin
                     lst_in = now_ff;
                     if (cur_ff < dem_ff) begin
                        nv = clamp_speed($signed({9'd0, cur_ff}) + $signed({9'd0, accel_ff}));
                     end else begin
                        nv = clamp_speed($signed({9'd0, cur_ff}) - $signed({9'd0, accel_ff}));
                     end
                  end
               end
            end
            if (nv != cur_ff) begin
               cur_in = nv;
               chg_in = 1'b1;
            end
         end
         // Hand the result to the output register once it is free
         esrb_pkg::OP_EMIT: begin
            flag = busy;
            if (!busy) begin
               ovalid_in = 1'b1;
               ospeed_in = cur_ff;
               ochg_in   = chg_ff;
               odem_in   = dem_ff;
               ohold_in  = hold_ff;
               orec_in   = rec_ff;
            end
         end
         default: flag = 1'b0;
      endcase
   end

   // Control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff    <= esrb_pkg::RST_COUNTS_PER_STEP;
         inv_ff    <= esrb_pkg::RST_INVERT_DIRECTION;
         sps_ff    <= esrb_pkg::RST_SPEED_PER_STEP;
         hyst_ff   <= esrb_pkg::RST_STEP_HYSTERESIS;
         tick_ff   <= esrb_pkg::RST_BRAKE_TICK_MS;
         decel_ff  <= esrb_pkg::RST_DECEL_PER_TICK;
         accel_ff  <= esrb_pkg::RST_ACCEL_PER_TICK;
         deb_ff    <= esrb_pkg::RST_TOUCH_DEBOUNCE_MS;
         seen_ff   <= 1'b0;
         last_ff   <= 32'd0;
         rem_ff    <= 9'sd0;
         cur_ff    <= 7'd0;
         dem_ff    <= 7'd0;
         hold_ff   <= 1'b0;
         rec_ff    <= 1'b0;
         lst_ff    <= 32'd0;
         lht_ff    <= 32'd0;
         divc_ff   <= 5'd0;
         chg_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         cps_ff    <= cps_in;
         inv_ff    <= inv_in;
         sps_ff    <= sps_in;
         hyst_ff   <= hyst_in;
         tick_ff   <= tick_in;
         decel_ff  <= decel_in;
         accel_ff  <= accel_in;
         deb_ff    <= deb_in;
         seen_ff   <= seen_in;
         last_ff   <= last_in;
         rem_ff    <= rem_in;
         cur_ff    <= cur_in;
         dem_ff    <= dem_in;
         hold_ff   <= hold_in;
         rec_ff    <= rec_in;
         lst_ff    <= lst_in;
         lht_ff    <= lht_in;
         divc_ff   <= divc_in;
         chg_ff    <= chg_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      touch_ff  <= touch_in;
      now_ff    <= now_in;
      divq_ff   <= divq_in;
      divr_ff   <= divr_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      ospeed_ff <= ospeed_in;
      ochg_ff   <= ochg_in;
      odem_ff   <= odem_in;
      ohold_ff  <= ohold_in;
      orec_ff   <= orec_in;
   end

endmodule

// File: rtl/core/esrb_chk.sv
module esrb_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_speed,
   input logic [6:0] rsp_demand,
   input logic       rsp_holding,
   input logic       rsp_recovering
);

   // Speed stays within the saturation range
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed <= esrb_pkg::SPEED_MAX))
      else $error("speed above limit");

   // Demand stays within the saturation range
   a_demand_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_demand <= esrb_pkg::SPEED_MAX))
      else $error("demand above limit");

   // Hold and recovery never show together
   a_brake_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_holding && rsp_recovering))
      else $error("hold and recovery both set");

   // One sample at a time: ready drops after a transaction
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted while busy");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn under stall");

endmodule

bind encoder_speed_ramp_with_brake esrb_chk u_esrb_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_speed      (rsp_chan.speed),
   .rsp_demand     (rsp_chan.demand),
   .rsp_holding    (rsp_chan.brake_holding),
   .rsp_recovering (rsp_chan.brake_recovering)
);

// File: test/esrb_result_checker.sv
`timescale 1ns / 100ps

module esrb_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   esrb_req_if                            req_mon,
   esrb_rsp_if                            rsp_mon,
   input  logic                           csr_we,
   input  logic [esrb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [esrb_pkg::CSR_DAT_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             samples_pending,
   output int                             results_checked,
   output int                             changes_seen,
   output int                             holds_seen,
   output int                             recoveries_seen
);

   typedef struct packed {
      logic [esrb_pkg::SPEED_W-1:0] speed;
      logic                         changed;
      logic [esrb_pkg::SPEED_W-1:0] demand;
      logic                         holding;
      logic                         recovering;
   } speed_report_type;

   // Register copies, updated from the CSR port
   logic [7:0]  cfg_counts_per_step;
   logic        cfg_invert;
   logic [6:0]  cfg_speed_per_step;
   logic [7:0]  cfg_hysteresis;
   logic [15:0] cfg_tick_ms;
   logic [6:0]  cfg_decel;
   logic [6:0]  cfg_accel;
   logic [15:0] cfg_debounce_ms;

   // Tracking state of the speed ramp
   bit                           seen_first;
   logic [esrb_pkg::COUNT_W-1:0] last_pos;
   longint                       count_rem;
   int                           cur_speed;
   int                           demand_speed;
   bit                           holding;
   bit                           recovering;
   logic [esrb_pkg::TIME_W-1:0]  last_step_ms;
   logic [esrb_pkg::TIME_W-1:0]  last_hold_ms;

   speed_report_type pending_reports[$];
   speed_report_type want;

   function automatic int clamp_speed(input longint v);
      if (v < 0)
         return 0;
      if (v > longint'(esrb_pkg::SPEED_MAX))
         return int'(esrb_pkg::SPEED_MAX);
      return int'(v);
   endfunction

   // Returns 1 when the commanded speed actually moves
   function automatic bit set_speed(input longint v);
      int s;
      s = clamp_speed(v);
      if (s == cur_speed)
         return 1'b0;
      cur_speed = s;
      return 1'b1;
   endfunction

   function automatic speed_report_type next_speed_report(
         input logic [esrb_pkg::COUNT_W-1:0] raw,
         input logic touch,
         input logic [esrb_pkg::TIME_W-1:0] now);
      logic [esrb_pkg::COUNT_W-1:0] pos;
      logic [esrb_pkg::COUNT_W-1:0] delta;
      longint                       acc;
      longint                       cps;
      longint                       steps;
      longint                       mag;
      longint                       nd;
      longint                       ramp_step;
      logic                         changed;
      speed_report_type             rep;

      changed = 1'b0;
      pos = cfg_invert ? (32'd0 - raw) : raw;

      // Encoder: turn position deltas into whole detent steps, keep the leftover
      if (!seen_first) begin
         last_pos = pos;
         seen_first = 1'b1;
      end else begin
         delta = pos - last_pos;
         last_pos = pos;
         if (delta != '0) begin
            cps = (cfg_counts_per_step == 8'd0) ? 64'sd1 : longint'(cfg_counts_per_step);
            acc = count_rem + longint'($signed(delta));
            steps = acc / cps;
            count_rem = acc - steps * cps;
            mag = (steps < 0) ? -steps : steps;
            if (steps != 0 && mag >= longint'(cfg_hysteresis)) begin
               nd = longint'(clamp_speed(longint'(demand_speed)
                                         + steps * longint'(cfg_speed_per_step)));
               if (nd != demand_speed) begin
                  demand_speed = int'(nd);
                  // during brake activity only the demand follows the knob
                  if (!holding && !recovering)
                     changed = set_speed(nd);
               end
            end
         end
      end

      // Brake: start a hold once the debounce window has passed
      if (touch && !holding && 32'(now - last_hold_ms) > 32'(cfg_debounce_ms)) begin
         holding = 1'b1;
         recovering = 1'b0;
         last_step_ms = now;
         last_hold_ms = now;
      end
      if (holding && touch) begin
         if (32'(now - last_step_ms) >= 32'(cfg_tick_ms)) begin
            last_step_ms = now;
            if (set_speed(longint'(cur_speed) - longint'(cfg_decel)))
               changed = 1'b1;
         end
      end else begin
         // release turns the hold into a recovery ramp
         if (holding) begin
            holding = 1'b0;
            recovering = 1'b1;
            last_step_ms = now;
         end
         if (recovering) begin
            if (cur_speed == demand_speed) begin
               recovering = 1'b0;
            end else if (32'(now - last_step_ms) >= 32'(cfg_tick_ms)) begin
               ramp_step = (cur_speed < demand_speed) ? longint'(cfg_accel)
                                                      : -longint'(cfg_accel);
               last_step_ms = now;
               if (set_speed(longint'(cur_speed) + ramp_step))
                  changed = 1'b1;
            end
         end
      end

      rep.speed      = esrb_pkg::SPEED_W'(cur_speed);
      rep.changed    = changed;
      rep.demand     = esrb_pkg::SPEED_W'(demand_speed);
      rep.holding    = holding;
      rep.recovering = recovering;
      return rep;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] expected,
                                         input logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
                  actual);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_counts_per_step = esrb_pkg::RST_COUNTS_PER_STEP;
         cfg_invert          = esrb_pkg::RST_INVERT_DIRECTION;
         cfg_speed_per_step  = esrb_pkg::RST_SPEED_PER_STEP;
         cfg_hysteresis      = esrb_pkg::RST_STEP_HYSTERESIS;
         cfg_tick_ms         = esrb_pkg::RST_BRAKE_TICK_MS;
         cfg_decel           = esrb_pkg::RST_DECEL_PER_TICK;
         cfg_accel           = esrb_pkg::RST_ACCEL_PER_TICK;
         cfg_debounce_ms     = esrb_pkg::RST_TOUCH_DEBOUNCE_MS;
         seen_first   = 1'b0;
         last_pos     = '0;
         count_rem    = 0;
         cur_speed    = 0;
         demand_speed = 0;
         holding      = 1'b0;
         recovering   = 1'b0;
         last_step_ms = '0;
         last_hold_ms = '0;
         pending_reports.delete();
         mismatch_count  = 0;
         results_checked = 0;
         changes_seen    = 0;
         holds_seen      = 0;
         recoveries_seen = 0;
      end else begin
         // Register writes land at this edge
         if (csr_we === 1'b1) begin
            case (csr_index)
               esrb_pkg::REG_COUNTS_PER_STEP:   cfg_counts_per_step = csr_wdata[7:0];
               esrb_pkg::REG_INVERT_DIRECTION:  cfg_invert          = csr_wdata[0];
               esrb_pkg::REG_SPEED_PER_STEP:    cfg_speed_per_step  = csr_wdata[6:0];
               esrb_pkg::REG_STEP_HYSTERESIS:   cfg_hysteresis      = csr_wdata[7:0];
               esrb_pkg::REG_BRAKE_TICK_MS:     cfg_tick_ms         = csr_wdata[15:0];
               esrb_pkg::REG_DECEL_PER_TICK:    cfg_decel           = csr_wdata[6:0];
               esrb_pkg::REG_ACCEL_PER_TICK:    cfg_accel           = csr_wdata[6:0];
               esrb_pkg::REG_TOUCH_DEBOUNCE_MS: cfg_debounce_ms     = csr_wdata[15:0];
               default: ;
            endcase
         end

         // Compare a result transaction with the oldest expectation
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: result with none expected, actual speed %0d demand %0d",
                        $time, rsp_mon.speed, rsp_mon.demand);
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("speed", 32'(want.speed), 32'(rsp_mon.speed));
               compare_field("speed_changed", 32'(want.changed),
                             32'(rsp_mon.speed_changed));
               compare_field("demand", 32'(want.demand), 32'(rsp_mon.demand));
               compare_field("brake_holding", 32'(want.holding),
                             32'(rsp_mon.brake_holding));
               compare_field("brake_recovering", 32'(want.recovering),
                             32'(rsp_mon.brake_recovering));
               results_checked++;
               changes_seen    += int'(want.changed);
               holds_seen      += int'(want.holding);
               recoveries_seen += int'(want.recovering);
            end
         end

         // Predict the result of an accepted sample
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            pending_reports.push_back(next_speed_report(req_mon.encoder_count,
                                                        req_mon.touching, req_mon.now_ms));
      end
      samples_pending = pending_reports.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int SAMPLE_TARGET = 1350;
   localparam int RANDOM_PHASES = 9;
   localparam int DRAIN_CYCLES  = 45;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int STALL_CYCLES  = 600;

   typedef struct {
      logic [7:0]  counts_per_step;
      logic        invert;
      logic [6:0]  speed_per_step;
      logic [7:0]  hysteresis;
      logic [15:0] tick_ms;
      logic [6:0]  decel;
      logic [6:0]  accel;
      logic [15:0] debounce_ms;
   } ramp_settings_type;

   typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_we    = 1'b0;
   logic [esrb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [esrb_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int samples_pending;
   int results_checked;
   int changes_seen;
   int holds_seen;
   int recoveries_seen;

   int cycle_count    = 0;
   int samples_sent   = 0;
   int settings_used  = 0;
   int burst_left     = 0;

   ramp_settings_type            active;
   ramp_settings_type            next_settings;
   logic [esrb_pkg::COUNT_W-1:0] enc_pos;
   logic [esrb_pkg::TIME_W-1:0]  sim_now;
   bit                           touch_state;
   bit                           touch_noise;
   int                           touch_left;
   int                           cps_eff;
   int                           enc_span;
   int                           time_span;
   logic                         touch_bit;

   rx_mode_type rx_mode;
   int          rx_left;
   bit          stalled_once;

   esrb_req_if req_chan ();
   esrb_rsp_if rsp_chan ();

   encoder_speed_ramp_with_brake DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   esrb_result_checker speed_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .samples_pending (samples_pending),
      .results_checked (results_checked),
      .changes_seen    (changes_seen),
      .holds_seen      (holds_seen),
      .recoveries_seen (recoveries_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  samples_pending);
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(input logic [esrb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [esrb_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Program every register, then release the write strobe
   task automatic apply_settings(input ramp_settings_type s);
      write_reg(esrb_pkg::REG_COUNTS_PER_STEP,   esrb_pkg::CSR_DAT_W'(s.counts_per_step));
      write_reg(esrb_pkg::REG_INVERT_DIRECTION,  esrb_pkg::CSR_DAT_W'(s.invert));
      write_reg(esrb_pkg::REG_SPEED_PER_STEP,    esrb_pkg::CSR_DAT_W'(s.speed_per_step));
      write_reg(esrb_pkg::REG_STEP_HYSTERESIS,   esrb_pkg::CSR_DAT_W'(s.hysteresis));
      write_reg(esrb_pkg::REG_BRAKE_TICK_MS,     esrb_pkg::CSR_DAT_W'(s.tick_ms));
      write_reg(esrb_pkg::REG_DECEL_PER_TICK,    esrb_pkg::CSR_DAT_W'(s.decel));
      write_reg(esrb_pkg::REG_ACCEL_PER_TICK,    esrb_pkg::CSR_DAT_W'(s.accel));
      write_reg(esrb_pkg::REG_TOUCH_DEBOUNCE_MS, esrb_pkg::CSR_DAT_W'(s.debounce_ms));
      @(negedge clock);
      csr_we <= 1'b0;
      active = s;
      settings_used++;
   endtask

   // Offer one sample, in bursts with random gaps in between
   task automatic offer_sample(input logic [esrb_pkg::COUNT_W-1:0] count, input logic touch,
                               input logic [esrb_pkg::TIME_W-1:0] now);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.encoder_count <= count;
      req_chan.touching      <= touch;
      req_chan.now_ms        <= now;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      samples_sent++;
   endtask

   // Drop valid, wait for every expected result, then let the block settle
   task automatic wait_quiet();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (samples_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Receiver: stall on changing patterns, with one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      rx_left = 0;
      stalled_once = 1'b0;
      forever begin
         @(negedge clock);
         if (!stalled_once && samples_sent >= 400) begin
            stalled_once = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
               RX_STREAM: rsp_chan.ready <= 1'b1;
               RX_COIN:   rsp_chan.ready <= ($urandom_range(0, 1) == 0);
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 5) == 0);
               default:   rsp_chan.ready <= ((rx_left % 7) < 3);
            endcase
         end
      end
   end

   initial begin
      req_chan.valid         <= 1'b0;
      req_chan.encoder_count <= '0;
      req_chan.touching      <= 1'b0;
      req_chan.now_ms        <= '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: wraps, hysteresis, saturation, debounce edge, hold and recovery
      apply_settings('{8'd4, 1'b0, 7'd10, 8'd2, 16'd50, 7'd5, 7'd3, 16'd200});
      offer_sample(32'h7FFF_FFFF, 1'b0, 32'd0);
      offer_sample(32'h8000_0000, 1'b0, 32'd10);
      offer_sample(32'h8000_0000, 1'b0, 32'd20);
      offer_sample(32'h8000_0003, 1'b0, 32'd30);
      offer_sample(32'h8000_000B, 1'b0, 32'd40);
      offer_sample(32'h0000_0003, 1'b0, 32'd50);
      offer_sample(32'h7FFF_FFFF, 1'b0, 32'd60);
      offer_sample(32'h7FFF_FFFF, 1'b1, 32'd300);
      offer_sample(32'h7FFF_FFDF, 1'b1, 32'd350);
      offer_sample(32'h7FFF_FFDF, 1'b1, 32'd399);
      offer_sample(32'h7FFF_FFDF, 1'b0, 32'd410);
      offer_sample(32'h7FFF_FFDF, 1'b1, 32'd500);
      offer_sample(32'h7FFF_FFDF, 1'b1, 32'd501);
      offer_sample(32'h7FFF_FFDF, 1'b0, 32'd551);
      offer_sample(32'h7FFF_FFDF, 1'b0, 32'd601);
      offer_sample(32'h7FFF_FFE7, 1'b0, 32'd651);
      offer_sample(32'h7FFF_FFE7, 1'b0, 32'hFFFF_FFF0);
      offer_sample(32'hFFFF_FFFF, 1'b1, 32'h0000_0010);
      offer_sample(32'hFFFF_FFFF, 1'b1, 32'h0000_0060);
      offer_sample(32'h0000_0000, 1'b0, 32'h0000_0070);
      wait_quiet();

      // Directed: zero counts per step, flipped direction, zero tick and debounce
      apply_settings('{8'd0, 1'b1, 7'd20, 8'd0, 16'd0, 7'd7, 7'd5, 16'd0});
      offer_sample(32'h0000_0000, 1'b0, 32'h0000_0080);
      offer_sample(32'h0000_0005, 1'b0, 32'h0000_0090);
      offer_sample(32'h0000_0005, 1'b1, 32'h0000_00A0);
      offer_sample(32'h0000_0005, 1'b1, 32'h0000_00A0);
      offer_sample(32'h0000_0005, 1'b0, 32'h0000_00A0);
      enc_pos = 32'h0000_0005;
      sim_now = 32'h0000_00A0;
      touch_state = 1'b0;
      touch_left = 0;
      wait_quiet();

      // Random phases: defaults, both extremes, then random settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: next_settings = '{esrb_pkg::RST_COUNTS_PER_STEP,
                                 esrb_pkg::RST_INVERT_DIRECTION,
                                 esrb_pkg::RST_SPEED_PER_STEP,
                                 esrb_pkg::RST_STEP_HYSTERESIS,
                                 esrb_pkg::RST_BRAKE_TICK_MS,
                                 esrb_pkg::RST_DECEL_PER_TICK,
                                 esrb_pkg::RST_ACCEL_PER_TICK,
                                 esrb_pkg::RST_TOUCH_DEBOUNCE_MS};
            1: next_settings = '{8'd1, 1'b0, 7'd126, 8'd0, 16'd0, 7'd126, 7'd126, 16'd0};
            2: next_settings = '{8'd255, 1'b1, 7'd1, 8'd255, 16'd65535, 7'd1, 7'd1, 16'd65535};
            default: begin
               next_settings.counts_per_step = ($urandom_range(0, 1) == 0) ?
                  8'($urandom_range(0, 8)) : 8'($urandom_range(0, 255));
               next_settings.invert = 1'($urandom_range(0, 1));
               next_settings.speed_per_step = ($urandom_range(0, 1) == 0) ?
                  7'($urandom_range(1, 12)) : 7'($urandom_range(1, 126));
               next_settings.hysteresis = ($urandom_range(0, 3) == 0) ?
                  8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
               next_settings.tick_ms = 16'($urandom_range(0, 200));
               next_settings.decel = ($urandom_range(0, 1) == 0) ?
                  7'($urandom_range(1, 20)) : 7'($urandom_range(1, 126));
               next_settings.accel = ($urandom_range(0, 1) == 0) ?
                  7'($urandom_range(1, 20)) : 7'($urandom_range(1, 126));
               next_settings.debounce_ms = 16'($urandom_range(0, 400));
            end
         endcase
         apply_settings(next_settings);
         cps_eff   = (active.counts_per_step == 8'd0) ? 1 : int'(active.counts_per_step);
         enc_span  = 3 * cps_eff + 3;
         time_span = 2 * int'(active.tick_ms) + 20;

         repeat (SAMPLE_TARGET / RANDOM_PHASES) begin
            // Touch gestures: press and release runs, some runs pure noise
            if (touch_left == 0) begin
               touch_noise = ($urandom_range(0, 4) == 0);
               touch_state = !touch_state;
               touch_left  = touch_state ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end
            touch_left--;
            touch_bit = touch_noise ? 1'($urandom_range(0, 1)) : touch_state;

            // Advance time mostly around the tick period, sometimes jump anywhere
            case ($urandom_range(0, 9))
               0:       sim_now = $urandom();
               1, 2:    sim_now = sim_now + $urandom_range(0, 20);
               default: sim_now = sim_now + $urandom_range(0, time_span);
            endcase

            // Move the knob by a few detents, hold it, or jump
            case ($urandom_range(0, 19))
               0:          enc_pos = $urandom();
               1:          enc_pos = enc_pos + $urandom();
               2, 3, 4:    ;
               default:    enc_pos = enc_pos + ($urandom_range(0, 2 * enc_span) - enc_span);
            endcase

            offer_sample(enc_pos, touch_bit, sim_now);
         end
         wait_quiet();
      end

      $display("ran %0d samples under %0d register settings, one long result stall",
               samples_sent, settings_used);
      $display("%0d results checked: %0d speed changes, %0d in hold, %0d recovering",
               results_checked, changes_seen, holds_seen, recoveries_seen);
      if (mismatch_count == 0 && samples_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
